// ----- hdl/salru_pkg.sv -----
// shared types, codes and constants of the set-associative lru cache controller
package salru_pkg;

    // default geometry
    localparam int SETS_DEF            = 8;
    localparam int WAYS_DEF            = 4;
    localparam int WORDS_PER_BLOCK_DEF = 4;
    localparam int BYTES_PER_WORD_DEF  = 4;

    // fixed field widths
    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 10;
    localparam int CYC_W      = 8;
    localparam int ABITS_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // register reset values
    localparam logic [ABITS_W-1:0] ADDRESS_BITS_RST = ABITS_W'(32);
    localparam logic [CYC_W-1:0]   HIT_CYCLES_RST   = CYC_W'(1);
    localparam logic [CYC_W-1:0]   MISS_CYCLES_RST  = CYC_W'(10);
    localparam logic [CYC_W-1:0]   WB_CYCLES_RST    = CYC_W'(10);

    // access codes
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADDRESS_BITS = 2'd0,
        REG_HIT_CYCLES   = 2'd1,
        REG_MISS_CYCLES  = 2'd2,
        REG_WB_CYCLES    = 2'd3
    } cfg_reg_t;

    // status of one set lookup
    typedef struct packed {
        logic hit;
        logic victim_dirty;
    } lookup_status_t;

    // floor of log2, for elaboration
    function automatic int flog2(input int x);
        int n;
        int v;
        n = 0;
        v = x;
        while (v > 1) begin
            v = v >> 1;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

// ----- hdl/salru_ram.sv -----
// generic single-port-write, registered-read ram
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/salru_lookup.sv -----
// tag match, victim choice and lru reorder for one set
module salru_lookup
    import salru_pkg::*;
#(
    parameter int WAYS  = WAYS_DEF,
    parameter int TAG_W = 25,
    parameter int WB    = 2
) (
    input  logic [WAYS*TAG_W-1:0] tags,
    input  logic [WAYS-1:0]       valid,
    input  logic [WAYS-1:0]       dirty,
    input  logic [WAYS*WB-1:0]    recency,
    input  logic [TAG_W-1:0]      tag,
    output lookup_status_t        status,
    output logic [WB-1:0]         way,
    output logic [WAYS*WB-1:0]    recency_new
);

    logic              hit;
    logic [WB-1:0]     hit_way;
    logic [WB-1:0]     victim;
    logic [WB-1:0]     pos;
    logic [WAYS*WB-1:0] rec_up;

    // first matching way wins
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && valid[w] && (tags[w*TAG_W +: TAG_W] == tag))
            begin
                hit     = 1'b1;
                hit_way = WB'(w);
            end
        end
    end

    // least recent way is the victim on a miss
    assign victim = recency[WB-1:0];
    assign way    = hit ? hit_way : victim;

    assign status.hit          = hit;
    assign status.victim_dirty = valid[victim] & dirty[victim];

    // position of the used way in the order
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (recency[i*WB +: WB] == way)
            begin
                pos = WB'(i);
            end
        end
    end

    // move the used way to the most recent end
    assign rec_up = recency >> WB;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            if (i == WAYS - 1)
            begin
                recency_new[i*WB +: WB] = way;
            end
            else if (WB'(i) < pos)
            begin
                recency_new[i*WB +: WB] = recency[i*WB +: WB];
            end
            else
            begin
                recency_new[i*WB +: WB] = rec_up[i*WB +: WB];
            end
        end
    end

endmodule

// ----- hdl/set_assoc_lru_cache_controller_unit.sv -----
// set-associative write-back lru cache controller: tag, dirty and recency bookkeeping
// read/write: accepted when start is high and busy low (tag ram read, then read-modify-write
//   in S_LOOK); the word on done is registered there and shows as busy falls again
// flush: each of the 2**index_bits sets in turn, a tag ram read then a scan of its ways;
//   last word from S_FL_END after the walk; one word per dirty block, or one empty word
// reset: lines invalid, recency 0..WAYS-1 per set, registers at reset values; usable the
//   cycle after reset, no clearing pass; results cannot be stalled
module set_assoc_lru_cache_controller_unit
    import salru_pkg::*;
#(
    parameter int SETS            = SETS_DEF,
    parameter int WAYS            = WAYS_DEF,
    parameter int WORDS_PER_BLOCK = WORDS_PER_BLOCK_DEF,
    parameter int BYTES_PER_WORD  = BYTES_PER_WORD_DEF,
    localparam int IB    = flog2(SETS),
    localparam int SET_W = (IB > 0) ? IB : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            action,
    input  logic [ADDR_W-1:0]     address,
    output logic                  busy,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic                  hit,
    output logic [SET_W-1:0]      set_index,
    output logic [TIME_W-1:0]     cycles_taken,
    output logic                  writeback,
    output logic [ADDR_W-1:0]     writeback_address,
    output logic                  last
);

    localparam int OB       = flog2(WORDS_PER_BLOCK * BYTES_PER_WORD);
    localparam int TAG_W    = ADDR_W - OB - IB;
    localparam int WB       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AW       = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W    = WAYS * TAG_W + WAYS + WAYS * WB;
    localparam int N_WALK   = 1 << IB;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(N_WALK - 1);
    localparam logic [WB-1:0]    LAST_WAY = WB'(WAYS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_FL_READ,
        S_FL_SCAN,
        S_FL_END
    } state_t;

    // configuration registers
    logic [ABITS_W-1:0] address_bits_reg;
    logic [CYC_W-1:0]   hit_cycles_reg;
    logic [CYC_W-1:0]   miss_cycles_reg;
    logic [CYC_W-1:0]   wb_cycles_reg;

    // control and payload registers
    state_t             state_reg;
    logic               write_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [SET_W-1:0]   cur_set_reg;
    logic [WB-1:0]      way_cnt_reg;
    logic [WAYS-1:0]    valid_reg [SETS];
    logic               pend_valid_reg;
    logic [SET_W-1:0]   pend_set_reg;
    logic [ADDR_W-1:0]  pend_addr_reg;
    logic               done_reg;
    logic               hit_reg;
    logic [SET_W-1:0]   set_index_reg;
    logic [TIME_W-1:0]  cycles_taken_reg;
    logic               writeback_reg;
    logic [ADDR_W-1:0]  wb_addr_reg;
    logic               last_reg;

    // input address split
    logic [ADDR_W-1:0]  in_masked;
    logic [SET_W-1:0]   in_set;
    logic [TAG_W-1:0]   in_tag;
    logic               in_accept;

    // ram side
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ROW_W-1:0]   ram_rdata;

    // row fields and lookup results
    logic [WAYS*TAG_W-1:0] row_tags;
    logic [WAYS-1:0]       row_dirty;
    logic [WAYS*WB-1:0]    row_rec;
    logic [WAYS*WB-1:0]    rec_init;
    logic [WAYS*WB-1:0]    rec_eff;
    logic [WAYS-1:0]       set_valid;
    lookup_status_t        lk_status;
    logic [WB-1:0]         lk_way;
    logic [WAYS*WB-1:0]    lk_rec_new;
    logic [WAYS*TAG_W-1:0] tags_new;
    logic [WAYS-1:0]       dirty_new;
    logic [ADDR_W-1:0]     set_part;
    logic [ADDR_W-1:0]     victim_addr;
    logic [ADDR_W-1:0]     scan_addr;
    logic                  scan_found;
    logic [TIME_W-1:0]     miss_time;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_bits_reg <= ADDRESS_BITS_RST;
            hit_cycles_reg   <= HIT_CYCLES_RST;
            miss_cycles_reg  <= MISS_CYCLES_RST;
            wb_cycles_reg    <= WB_CYCLES_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ADDRESS_BITS: address_bits_reg <= cfg_data[ABITS_W-1:0];
                REG_HIT_CYCLES:   hit_cycles_reg   <= cfg_data;
                REG_MISS_CYCLES:  miss_cycles_reg  <= cfg_data;
                REG_WB_CYCLES:    wb_cycles_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // mask the address and split it into set and tag
    assign in_masked = address & ~({ADDR_W{1'b1}} << address_bits_reg);
    assign in_set    = (IB == 0) ? '0 : SET_W'(in_masked >> OB);
    assign in_tag    = TAG_W'(in_masked >> (OB + IB));
    assign in_accept = start && (state_reg == S_IDLE);

    // ram port control
    assign ram_re    = (in_accept && ((action == ACT_READ) || (action == ACT_WRITE)))
                       || (state_reg == S_FL_READ);
    assign ram_raddr = (state_reg == S_IDLE) ? AW'(in_set) : AW'(cur_set_reg);
    assign ram_waddr = AW'(cur_set_reg);
    assign ram_we    = (state_reg == S_LOOK)
                       || ((state_reg == S_FL_SCAN) && (way_cnt_reg == LAST_WAY));
    assign ram_wdata = (state_reg == S_LOOK) ? {tags_new, dirty_new, lk_rec_new}
                                             : {row_tags, {WAYS{1'b0}}, row_rec};

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // row layout: tags, dirty bits, recency order least recent first
    assign row_tags  = ram_rdata[ROW_W-1 -: WAYS*TAG_W];
    assign row_dirty = ram_rdata[WAYS*WB +: WAYS];
    assign row_rec   = ram_rdata[WAYS*WB-1:0];
    assign set_valid = valid_reg[AW'(cur_set_reg)];

    // an untouched set still has its reset order
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            rec_init[i*WB +: WB] = WB'(i);
        end
    end

    assign rec_eff = (|set_valid) ? row_rec : rec_init;

    salru_lookup #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .WB    (WB)
    ) u_lookup (
        .tags        (row_tags),
        .valid       (set_valid),
        .dirty       (row_dirty),
        .recency     (rec_eff),
        .tag         (tag_reg),
        .status      (lk_status),
        .way         (lk_way),
        .recency_new (lk_rec_new)
    );

    // row update for an access
    always_comb
    begin
        tags_new  = row_tags;
        dirty_new = row_dirty;
        if (!lk_status.hit)
        begin
            tags_new[lk_way*TAG_W +: TAG_W] = tag_reg;
            dirty_new[lk_way]               = 1'b0;
        end
        if (write_reg)
        begin
            dirty_new[lk_way] = 1'b1;
        end
    end

    // block addresses for writeback
    assign set_part    = ADDR_W'(cur_set_reg) << OB;
    assign victim_addr = (ADDR_W'(row_tags[lk_way*TAG_W +: TAG_W]) << (OB + IB)) | set_part;
    assign scan_addr   = (ADDR_W'(row_tags[way_cnt_reg*TAG_W +: TAG_W]) << (OB + IB))
                         | set_part;
    assign scan_found  = set_valid[way_cnt_reg] & row_dirty[way_cnt_reg];

    // miss time: block read, optional writeback, final hit
    assign miss_time = TIME_W'(miss_cycles_reg) + TIME_W'(hit_cycles_reg)
                       + (lk_status.victim_dirty ? TIME_W'(wb_cycles_reg) : '0);

    // sequencer with registered result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            way_cnt_reg    <= '0;
            cur_set_reg    <= '0;
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        case (action)
                            ACT_READ, ACT_WRITE:
                            begin
                                write_reg   <= (action == ACT_WRITE);
                                tag_reg     <= in_tag;
                                cur_set_reg <= in_set;
                                state_reg   <= S_LOOK;
                            end
                            ACT_FLUSH:
                            begin
                                cur_set_reg    <= '0;
                                pend_valid_reg <= 1'b0;
                                state_reg      <= S_FL_READ;
                            end
                            default: ;
                        endcase
                    end
                end

                // tag compare, row write back, result word
                S_LOOK:
                begin
                    valid_reg[AW'(cur_set_reg)][lk_way] <= 1'b1;
                    done_reg         <= 1'b1;
                    hit_reg          <= lk_status.hit;
                    set_index_reg    <= cur_set_reg;
                    cycles_taken_reg <= lk_status.hit ? TIME_W'(hit_cycles_reg) : miss_time;
                    writeback_reg    <= !lk_status.hit && lk_status.victim_dirty;
                    wb_addr_reg      <= (!lk_status.hit && lk_status.victim_dirty)
                                        ? victim_addr : '0;
                    last_reg         <= 1'b1;
                    state_reg        <= S_IDLE;
                end

                S_FL_READ:
                begin
                    way_cnt_reg <= '0;
                    state_reg   <= S_FL_SCAN;
                end

                // one way per cycle; a found block is held back until the next one is found, for last
                S_FL_SCAN:
                begin
                    if (scan_found)
                    begin
                        if (pend_valid_reg)
                        begin
                            done_reg         <= 1'b1;
                            hit_reg          <= 1'b0;
                            set_index_reg    <= pend_set_reg;
                            cycles_taken_reg <= '0;
                            writeback_reg    <= 1'b1;
                            wb_addr_reg      <= pend_addr_reg;
                            last_reg         <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_set_reg   <= cur_set_reg;
                        pend_addr_reg  <= scan_addr;
                    end
                    way_cnt_reg <= way_cnt_reg + WB'(1);
                    if (way_cnt_reg == LAST_WAY)
                    begin
                        if (cur_set_reg == LAST_SET)
                        begin
                            state_reg <= S_FL_END;
                        end
                        else
                        begin
                            cur_set_reg <= cur_set_reg + SET_W'(1);
                            state_reg   <= S_FL_READ;
                        end
                    end
                end

                // final flush word, or the empty word
                S_FL_END:
                begin
                    done_reg         <= 1'b1;
                    hit_reg          <= 1'b0;
                    set_index_reg    <= pend_valid_reg ? pend_set_reg : '0;
                    cycles_taken_reg <= '0;
                    writeback_reg    <= pend_valid_reg;
                    wb_addr_reg      <= pend_valid_reg ? pend_addr_reg : '0;
                    last_reg         <= 1'b1;
                    state_reg        <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign hit               = hit_reg;
    assign set_index         = set_index_reg;
    assign cycles_taken      = cycles_taken_reg;
    assign writeback         = writeback_reg;
    assign writeback_address = wb_addr_reg;
    assign last              = last_reg;

endmodule

// ----- tb/sv/salru_result_checker.sv -----
// result checker of the lru cache controller: tracks tags, dirty and recency, checks each word
module salru_result_checker
    import salru_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            action,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  busy,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  done,
    input  logic                  hit,
    input  logic [2:0]            set_index,
    input  logic [TIME_W-1:0]     cycles_taken,
    input  logic                  writeback,
    input  logic [ADDR_W-1:0]     writeback_address,
    input  logic                  last,
    output int                    errors,
    output int                    pending
);

    localparam int OFF_W = $clog2(WORDS_PER_BLOCK_DEF * BYTES_PER_WORD_DEF);
    localparam int IDX_W = $clog2(SETS_DEF);

    typedef struct packed {
        logic              hit;
        logic [2:0]        set_no;
        logic [TIME_W-1:0] cycles;
        logic              wb;
        logic [ADDR_W-1:0] wb_addr;
        logic              last;
    } cache_word_t;

    // shadow copy of the controller's registers and tag state
    logic [ABITS_W-1:0] addr_bits;
    logic [CYC_W-1:0]   hit_cyc;
    logic [CYC_W-1:0]   miss_cyc;
    logic [CYC_W-1:0]   wb_cyc;

    logic [ADDR_W-1:0] line_tag   [SETS_DEF][WAYS_DEF];
    bit                line_valid [SETS_DEF][WAYS_DEF];
    bit                line_dirty [SETS_DEF][WAYS_DEF];
    int                lru_order  [SETS_DEF][WAYS_DEF];

    cache_word_t expected_words[$];
    int          mismatch_cnt;

    // move a way to the most recent end of its set's order
    task automatic touch_way(input int s, input int w);
        int pos;
        int i;
        pos = 0;
        for (i = 0; i < WAYS_DEF; i++)
            if (lru_order[s][i] == w)
                pos = i;
        for (i = pos; i + 1 < WAYS_DEF; i++)
            lru_order[s][i] = lru_order[s][i + 1];
        lru_order[s][WAYS_DEF - 1] = w;
    endtask

    // lookup, refill and victim writeback of one read or write
    task automatic predict_lookup(input action_t act, input logic [ADDR_W-1:0] addr);
        int          eff_bits;
        logic [31:0] mask;
        logic [31:0] a;
        logic [31:0] tag;
        int          s;
        int          way;
        int          w;
        cache_word_t word;
        eff_bits = (addr_bits > 32) ? 32 : int'(addr_bits);
        mask = (eff_bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << eff_bits) - 32'd1);
        a = addr & mask;
        s = int'((a >> OFF_W) % SETS_DEF);
        tag = a >> (OFF_W + IDX_W);
        word = '0;
        word.set_no = 3'(s);
        word.last = 1'b1;
        way = 0;
        for (w = 0; w < WAYS_DEF; w++)
            if (!word.hit && line_valid[s][w] && line_tag[s][w] == tag)
            begin
                word.hit = 1'b1;
                way = w;
            end
        if (word.hit)
        begin
            word.cycles = TIME_W'(hit_cyc);
        end
        else
        begin
            way = lru_order[s][0] % WAYS_DEF;
            word.cycles = TIME_W'(miss_cyc);
            // dirty victim goes back to memory first
            if (line_valid[s][way] && line_dirty[s][way])
            begin
                word.wb = 1'b1;
                word.wb_addr = (line_tag[s][way] << (OFF_W + IDX_W)) | (32'(s) << OFF_W);
                word.cycles = word.cycles + TIME_W'(wb_cyc);
            end
            line_tag[s][way] = tag;
            line_valid[s][way] = 1'b1;
            line_dirty[s][way] = 1'b0;
            word.cycles = word.cycles + TIME_W'(hit_cyc);
        end
        touch_way(s, way);
        if (act == ACT_WRITE)
            line_dirty[s][way] = 1'b1;
        expected_words.push_back(word);
    endtask

    // one word per dirty block in set then way order, or one empty word
    task automatic predict_flush();
        int          total;
        int          k;
        int          s;
        int          w;
        cache_word_t word;
        total = 0;
        for (s = 0; s < SETS_DEF; s++)
            for (w = 0; w < WAYS_DEF; w++)
                if (line_valid[s][w] && line_dirty[s][w])
                    total++;
        k = 0;
        for (s = 0; s < SETS_DEF; s++)
            for (w = 0; w < WAYS_DEF; w++)
                if (line_valid[s][w] && line_dirty[s][w])
                begin
                    word = '0;
                    word.set_no = 3'(s);
                    word.wb = 1'b1;
                    word.wb_addr = (line_tag[s][w] << (OFF_W + IDX_W)) | (32'(s) << OFF_W);
                    word.last = (k == total - 1);
                    line_dirty[s][w] = 1'b0;
                    expected_words.push_back(word);
                    k++;
                end
        if (total == 0)
        begin
            word = '0;
            word.last = 1'b1;
            expected_words.push_back(word);
        end
    endtask

    // compare one delivered word with the oldest expectation
    task automatic check_word();
        cache_word_t got;
        cache_word_t exp_word;
        got = '{hit, set_index, cycles_taken, writeback, writeback_address, last};
        if (expected_words.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: unexpected word hit=%0b set=%0d cyc=%0d wb=%0b wba=%h last=%0b",
                         $realtime, got.hit, got.set_no, got.cycles, got.wb, got.wb_addr,
                         got.last);
        end
        else
        begin
            exp_word = expected_words.pop_front();
            if (got.hit !== exp_word.hit || got.set_no !== exp_word.set_no ||
                got.cycles !== exp_word.cycles || got.wb !== exp_word.wb ||
                got.wb_addr !== exp_word.wb_addr || got.last !== exp_word.last)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                begin
                    $display("%0t: mismatch, exp hit=%0b set=%0d cyc=%0d wb=%0b wba=%h last=%0b",
                             $realtime, exp_word.hit, exp_word.set_no, exp_word.cycles,
                             exp_word.wb, exp_word.wb_addr, exp_word.last);
                    $display("%0t:           got hit=%0b set=%0d cyc=%0d wb=%0b wba=%h last=%0b",
                             $realtime, got.hit, got.set_no, got.cycles, got.wb, got.wb_addr,
                             got.last);
                end
            end
        end
    endtask

    // watch the channels: results first, then register writes and new accesses
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_bits = ADDRESS_BITS_RST;
            hit_cyc = HIT_CYCLES_RST;
            miss_cyc = MISS_CYCLES_RST;
            wb_cyc = WB_CYCLES_RST;
            for (int s = 0; s < SETS_DEF; s++)
                for (int w = 0; w < WAYS_DEF; w++)
                begin
                    line_tag[s][w] = '0;
                    line_valid[s][w] = 1'b0;
                    line_dirty[s][w] = 1'b0;
                    lru_order[s][w] = w;
                end
            expected_words.delete();
            mismatch_cnt = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
                check_word();
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ADDRESS_BITS: addr_bits = cfg_data[ABITS_W-1:0];
                    REG_HIT_CYCLES:   hit_cyc = cfg_data;
                    REG_MISS_CYCLES:  miss_cyc = cfg_data;
                    REG_WB_CYCLES:    wb_cyc = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (action_t'(action))
                    ACT_READ, ACT_WRITE: predict_lookup(action_t'(action), address);
                    ACT_FLUSH:           predict_flush();
                    default: ;
                endcase
            end
            errors <= mismatch_cnt;
            pending <= expected_words.size();
        end
    end

endmodule

// ----- tb/sv/tb_set_assoc_lru_cache_controller_unit.sv -----
// testbench top of the lru cache controller: stimulus, register phases and verdict
module tb_set_assoc_lru_cache_controller_unit;
    import salru_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic [1:0]            action;
    logic [ADDR_W-1:0]     address;
    logic                  busy;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic                  hit;
    logic [2:0]            set_index;
    logic [TIME_W-1:0]     cycles_taken;
    logic                  writeback;
    logic [ADDR_W-1:0]     writeback_address;
    logic                  last;
    int                    errors;
    int                    pending;

    // register settings per phase: address bits, hit, miss read, writeback cycles
    logic [7:0] settings [8][4] = '{
        '{8'd32, 8'd1,   8'd10,  8'd10},
        '{8'd7,  8'd0,   8'd0,   8'd0},
        '{8'd63, 8'd255, 8'd255, 8'd255},
        '{8'd40, 8'd3,   8'd20,  8'd7},
        '{8'd8,  8'd2,   8'd255, 8'd0},
        '{8'd4,  8'd0,   8'd1,   8'd255},
        '{8'hC0, 8'd255, 8'd0,   8'd1},
        '{8'd32, 8'd1,   8'd10,  8'd10}
    };

    set_assoc_lru_cache_controller_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action), .address(address),
        .busy(busy), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .hit(hit), .set_index(set_index), .cycles_taken(cycles_taken),
        .writeback(writeback), .writeback_address(writeback_address), .last(last)
    );

    salru_result_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action), .address(address),
        .busy(busy), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .hit(hit), .set_index(set_index), .cycles_taken(cycles_taken),
        .writeback(writeback), .writeback_address(writeback_address), .last(last),
        .errors(errors), .pending(pending)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb_set_assoc_lru_cache_controller_unit: errors");
        $finish;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // present one word and hold it until the controller takes it
    task automatic send_word(input action_t act, input logic [ADDR_W-1:0] addr, input int gap);
        start <= 1'b1;
        action <= act;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every expected word is in and the controller is quiet
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input int p);
        write_reg(REG_ADDRESS_BITS, settings[p][0]);
        write_reg(REG_HIT_CYCLES, settings[p][1]);
        write_reg(REG_MISS_CYCLES, settings[p][2]);
        write_reg(REG_WB_CYCLES, settings[p][3]);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // accesses drawn from a small tag pool so sets fill, hit and evict
    task automatic random_words(input int count);
        logic [24:0] tag_pool [6];
        bit          quiet;
        int          k;
        int          r;
        action_t     act;
        logic [31:0] addr;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 6; i++)
            tag_pool[i] = 25'($urandom);
        quiet = ($urandom_range(0, 3) == 0);
        k = 0;
        while (k < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                act = ACT_READ;
            else if (r < 85)
                act = ACT_WRITE;
            else if (r < 94)
                act = ACT_FLUSH;
            else
                act = ACT_NONE;
            if ($urandom_range(0, 4) == 0)
                addr = $urandom;
            else
                addr = {tag_pool[$urandom_range(0, 5)], 3'($urandom), 4'($urandom)};
            send_word(act, addr, pick_gap(quiet));
            if (act != ACT_NONE)
                k++;
        end
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_READ;
        address = '0;
        cfg_write = 1'b0;
        cfg_index = REG_ADDRESS_BITS;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, hit after miss, dirty eviction, flush, empty flush, unused code
        send_word(ACT_READ,  32'h0000_0000, pick_gap(1'b0));
        send_word(ACT_WRITE, 32'h0000_0004, pick_gap(1'b0));
        send_word(ACT_READ,  32'hFFFF_FFFF, pick_gap(1'b0));
        send_word(ACT_WRITE, 32'hFFFF_FFF0, pick_gap(1'b0));
        send_word(ACT_WRITE, 32'h0000_0080, pick_gap(1'b0));
        send_word(ACT_READ,  32'h0000_0100, pick_gap(1'b0));
        send_word(ACT_WRITE, 32'h0000_0180, pick_gap(1'b0));
        send_word(ACT_READ,  32'h0000_0200, pick_gap(1'b0));
        send_word(ACT_READ,  32'h0000_0088, pick_gap(1'b0));
        send_word(ACT_WRITE, 32'h0000_0280, pick_gap(1'b0));
        send_word(ACT_FLUSH, 32'h1234_5678, pick_gap(1'b0));
        send_word(ACT_FLUSH, 32'hFFFF_FFFF, pick_gap(1'b0));
        send_word(ACT_NONE,  32'hDEAD_BEEF, pick_gap(1'b0));
        send_word(ACT_READ,  32'h8000_0070, pick_gap(1'b0));
        send_word(ACT_WRITE, 32'h7FFF_FF8C, pick_gap(1'b0));
        send_word(ACT_WRITE, 32'h8000_0074, pick_gap(1'b0));
        send_word(ACT_FLUSH, 32'h0000_0000, pick_gap(1'b0));

        // register phases, the last one with random settings
        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
            begin
                settings[7][0] = 8'($urandom);
                settings[7][1] = 8'($urandom);
                settings[7][2] = 8'($urandom);
                settings[7][3] = 8'($urandom);
            end
            drain();
            program_regs(p);
            random_words(20);
        end
        drain();

        if (errors == 0 && pending == 0)
            $display("tb_set_assoc_lru_cache_controller_unit: clean");
        else
            $display("tb_set_assoc_lru_cache_controller_unit: errors");
        $finish;
    end

endmodule
